/* design/dclx_pkg.sv */
// ============================================================================
// dclx_pkg
// Shared types, sizes and codes of the delta-compressed address index.
// ============================================================================
package dclx_pkg;

	localparam int MaxEntries  = 512;
	localparam int ChunkBits   = 512;
	localparam int HeadBits    = 32;
	localparam int ChunkStride = ChunkBits / 8;
	localparam int StoreBytes  = 4 * MaxEntries + ChunkStride;
	localparam int StoreWords  = StoreBytes / 4;
	localparam int RawAw       = $clog2(MaxEntries);
	localparam int WordAw      = $clog2(StoreWords);
	localparam int CntW        = RawAw + 1;

	typedef enum logic [2:0] {
		ST_LOADED    = 3'd0,
		ST_BUILT     = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NOT_BUILT = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] lba;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  index;
		logic [2:0]  delta_bytes;
		logic [9:0]  chunk_count;
		logic [18:0] stored_bits;
	} result_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_BLD_RD,
		FSM_BLD_WR,
		FSM_SRCH_RD,
		FSM_SRCH_H,
		FSM_SRCH_N,
		FSM_SCAN_RD,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	// entries per chunk for a delta width
	function automatic logic [CntW-1:0] epc_of(input logic [2:0] gb, input logic multi);
		logic [CntW-1:0] r;
		begin
			r = '1;
			if (!multi) r = CntW'(1);
			else begin
				unique case (gb)
					3'd2:    r = CntW'((ChunkBits - HeadBits) / 16 + 1);
					3'd3:    r = CntW'((ChunkBits - HeadBits) / 24 + 1);
					3'd4:    r = CntW'((ChunkBits - HeadBits) / 32 + 1);
					default: r = CntW'((ChunkBits - HeadBits) / 8 + 1);
				endcase
			end
			return r;
		end
	endfunction

endpackage

/* design/dclx_byte_store.sv */
// ============================================================================
// dclx_byte_store
// Byte-addressed chunk store built of four byte-lane RAMs; reads or writes a
// little-endian field of up to four bytes at any byte offset; read data is registered.
// ============================================================================
module dclx_byte_store (
	input  logic        clk,
	input  logic        we,
	input  logic [dclx_pkg::WordAw+1:0] addr,
	input  logic [2:0]  nbytes,
	input  logic [31:0] wdata,
	output logic [31:0] rdata
);
	localparam int Aw = dclx_pkg::WordAw + 2;

	logic [7:0] lane0 [dclx_pkg::StoreWords];
	logic [7:0] lane1 [dclx_pkg::StoreWords];
	logic [7:0] lane2 [dclx_pkg::StoreWords];
	logic [7:0] lane3 [dclx_pkg::StoreWords];

	logic [dclx_pkg::WordAw-1:0] wa [4];
	logic [3:0]  ok;
	logic [7:0]  wb [4];
	logic [1:0]  off_q;
	logic [2:0]  nb_q;
	logic [3:0]  ok_q;
	logic [7:0]  rb [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			logic [1:0] k;
			logic [Aw:0] a;
			k = 2'(l) - addr[1:0];
			a = {1'b0, addr} + (Aw+1)'(k);
			wa[l] = a[Aw-1:2];
			ok[l] = (a < (Aw+1)'(dclx_pkg::StoreBytes)) && ({1'b0, k} < nbytes);
			wb[l] = wdata[8*k +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (we && ok[0]) lane0[wa[0]] <= wb[0];
		if (we && ok[1]) lane1[wa[1]] <= wb[1];
		if (we && ok[2]) lane2[wa[2]] <= wb[2];
		if (we && ok[3]) lane3[wa[3]] <= wb[3];
		rb[0] <= lane0[wa[0]];
		rb[1] <= lane1[wa[1]];
		rb[2] <= lane2[wa[2]];
		rb[3] <= lane3[wa[3]];
		off_q <= addr[1:0];
		nb_q  <= nbytes;
		ok_q  <= ok;
	end

	always_comb begin
		rdata = '0;
		for (int k = 0; k < 4; k++) begin
			logic [1:0] l;
			l = 2'(k) + off_q;
			if (ok_q[l] && 3'(k) < nb_q) rdata[8*k +: 8] = rb[l];
		end
	end
endmodule

/* design/delta_compressed_lba_index_unit.sv */
// ============================================================================
// delta_compressed_lba_index_unit
// Sorted address set: loads addresses, packs them into delta-coded chunks and
// answers lookups by a chunk head search followed by a delta scan.
// ============================================================================
//  channel | signals                   | handshake
//  item    | start, busy, item         | taken when start && !busy
//  result  | done, result              | one-cycle strobe on done
// A load passes through the done state and shows its result on done; a building
// load first adds, per entry, a raw RAM read state then a chunk store write state.
// A lookup runs head search steps (read, head, next; the next state is skipped on
// a step at the last chunk), at most 6 steps for 32 chunks, then a read and a scan
// state per scanned entry: the head and up to 60 deltas, all on one store port.
// Reset clears the control state only; stores hold garbage until written.
// The receiver cannot stall: each result is shown once on done.
module delta_compressed_lba_index_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dclx_pkg::item_t    item,
	output logic               done,
	output dclx_pkg::result_t  result
);
	localparam int CntW = dclx_pkg::CntW;
	localparam int RawAw = dclx_pkg::RawAw;
	localparam int BAw = dclx_pkg::WordAw + 2;
	localparam int SW = CntW + 2;

	dclx_pkg::fsm_t state_q, state_d;

	logic [31:0] raw_mem [dclx_pkg::MaxEntries];
	logic [31:0] raw_rd_q;
	logic        raw_we;
	logic [RawAw-1:0] raw_wa, raw_ra;

	logic [CntW-1:0] count_q;
	logic [31:0] prev_q, gap_q, lba_q, acc_q, head_q, prev_a_q;
	logic [2:0]  gb_q;
	logic        built_q;
	logic [2:0]  status_q;
	logic [8:0]  index_q;
	logic [CntW-1:0] i_q, slot_q, ci_q, epc_q, nchunk_q, valid_q;
	logic signed [SW-1:0] s_q, e_q, mid_q;
	logic signed [SW-1:0] last_mid;
	logic [BAw-1:0] pos_q;
	logic [31:0] scan_sum;

	logic        bs_we;
	logic [BAw-1:0] bs_addr;
	logic [2:0]  bs_nb;
	logic [31:0] bs_wdata, bs_rdata;

	dclx_byte_store u_store (
		.clk(clk), .we(bs_we), .addr(bs_addr), .nbytes(bs_nb),
		.wdata(bs_wdata), .rdata(bs_rdata)
	);

	always_ff @(posedge clk) begin
		if (raw_we) raw_mem[raw_wa] <= item.lba;
		raw_rd_q <= raw_mem[raw_ra];
	end

	logic accept;
	assign accept = start && !busy;
	assign busy = state_q != dclx_pkg::FSM_IDLE;

	assign last_mid = SW'(nchunk_q) - SW'(1);
	assign scan_sum = acc_q + bs_rdata;

	// control values from the count after this beat's load
	logic [CntW-1:0] cnt_eff;
	logic [31:0] gap_new;
	logic [2:0]  gb_new;
	logic        full;
	always_comb begin
		logic [CntW-1:0] c0;
		logic [31:0] g0, g;
		c0 = built_q ? '0 : count_q;
		g0 = built_q ? '0 : gap_q;
		full = c0 >= CntW'(dclx_pkg::MaxEntries);
		g = item.lba - prev_q;
		gap_new = (!full && c0 != '0 && g > g0) ? g : g0;
		cnt_eff = full ? c0 : c0 + CntW'(1);
		if (cnt_eff <= CntW'(1)) gb_new = 3'd0;
		else if (gap_new[31:24] != 0) gb_new = 3'd4;
		else if (gap_new[23:16] != 0) gb_new = 3'd3;
		else if (gap_new[15:8] != 0) gb_new = 3'd2;
		else gb_new = 3'd1;
	end

	always_comb begin
		state_d = state_q;
		raw_we = 1'b0;
		raw_wa = count_q[RawAw-1:0];
		raw_ra = i_q[RawAw-1:0];
		bs_we = 1'b0;
		bs_addr = pos_q;
		bs_nb = 3'd4;
		bs_wdata = raw_rd_q;
		unique case (state_q)
			dclx_pkg::FSM_IDLE: begin
				if (accept) begin
					if (item.kind == 1'b0) begin
						if (!full) begin
							raw_we = 1'b1;
							raw_wa = built_q ? '0 : count_q[RawAw-1:0];
						end
						if (!item.last || cnt_eff == '0) state_d = dclx_pkg::FSM_DONE;
						else state_d = dclx_pkg::FSM_BLD_RD;
					end else if (!built_q) state_d = dclx_pkg::FSM_DONE;
					else state_d = dclx_pkg::FSM_SRCH_RD;
				end
			end
			dclx_pkg::FSM_BLD_RD: state_d = dclx_pkg::FSM_BLD_WR;
			dclx_pkg::FSM_BLD_WR: begin
				bs_we = 1'b1;
				if (slot_q != '0) begin
					bs_nb = gb_q;
					bs_wdata = raw_rd_q - prev_a_q;
				end
				state_d = (i_q + 1'b1 == count_q) ? dclx_pkg::FSM_DONE
					: dclx_pkg::FSM_BLD_RD;
			end
			dclx_pkg::FSM_SRCH_RD: begin
				bs_addr = BAw'(mid_q) * BAw'(dclx_pkg::ChunkStride);
				state_d = dclx_pkg::FSM_SRCH_H;
			end
			dclx_pkg::FSM_SRCH_H: begin
				bs_addr = BAw'(mid_q + SW'(1)) * BAw'(dclx_pkg::ChunkStride);
				if (mid_q == last_mid) begin
					if (bs_rdata <= lba_q) state_d = dclx_pkg::FSM_SCAN_RD;
					else if (s_q <= mid_q - SW'(1)) state_d = dclx_pkg::FSM_SRCH_RD;
					else state_d = dclx_pkg::FSM_DONE;
				end else state_d = dclx_pkg::FSM_SRCH_N;
			end
			dclx_pkg::FSM_SRCH_N: begin
				if (head_q <= lba_q && bs_rdata > lba_q) state_d = dclx_pkg::FSM_SCAN_RD;
				else if (head_q > lba_q)
					state_d = (s_q <= mid_q - SW'(1)) ? dclx_pkg::FSM_SRCH_RD
						: dclx_pkg::FSM_DONE;
				else
					state_d = (mid_q + SW'(1) <= e_q) ? dclx_pkg::FSM_SRCH_RD
						: dclx_pkg::FSM_DONE;
			end
			dclx_pkg::FSM_SCAN_RD: begin
				bs_nb = (i_q == '0) ? 3'd4 : gb_q;
				// the first read of a scan fetches the chunk head
				if (i_q == '0) bs_addr = BAw'(mid_q) * BAw'(dclx_pkg::ChunkStride);
				state_d = dclx_pkg::FSM_SCAN;
			end
			dclx_pkg::FSM_SCAN: begin
				if (scan_sum == lba_q) state_d = dclx_pkg::FSM_DONE;
				else state_d = (i_q + 1'b1 < valid_q) ? dclx_pkg::FSM_SCAN_RD
					: dclx_pkg::FSM_DONE;
			end
			dclx_pkg::FSM_DONE: state_d = dclx_pkg::FSM_IDLE;
			default: state_d = dclx_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dclx_pkg::FSM_IDLE;
			count_q <= '0;
			prev_q <= '0;
			gap_q <= '0;
			gb_q <= '0;
			built_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == dclx_pkg::FSM_DONE);
			unique case (state_q)
				dclx_pkg::FSM_IDLE: if (accept) begin
					lba_q <= item.lba;
					if (item.kind == 1'b0) begin
						count_q <= cnt_eff;
						gap_q <= gap_new;
						built_q <= item.last;
						if (!full) prev_q <= item.lba;
						index_q <= full ? '0 : 9'(cnt_eff - CntW'(1));
						if (full) status_q <= dclx_pkg::ST_FULL;
						else if (item.last) status_q <= dclx_pkg::ST_BUILT;
						else status_q <= dclx_pkg::ST_LOADED;
						if (item.last) begin
							gb_q <= gb_new;
							epc_q <= dclx_pkg::epc_of(gb_new, cnt_eff > CntW'(1));
							i_q <= '0;
							slot_q <= '0;
							ci_q <= '0;
						end else if (built_q) gb_q <= '0;
					end else begin
						index_q <= '0;
						if (!built_q) status_q <= dclx_pkg::ST_NOT_BUILT;
						else begin
							status_q <= dclx_pkg::ST_NOT_FOUND;
							s_q <= '0;
							e_q <= last_mid;
							mid_q <= last_mid >>> 1;
						end
					end
				end
				dclx_pkg::FSM_BLD_RD: begin
					if (slot_q == '0) pos_q <= BAw'(ci_q) * BAw'(dclx_pkg::ChunkStride);
				end
				dclx_pkg::FSM_BLD_WR: begin
					prev_a_q <= raw_rd_q;
					pos_q <= pos_q + ((slot_q == '0) ? BAw'(4) : BAw'(gb_q));
					i_q <= i_q + 1'b1;
					nchunk_q <= ci_q + CntW'(1);
					if (slot_q + 1'b1 == epc_q) begin
						slot_q <= '0;
						ci_q <= ci_q + 1'b1;
					end else slot_q <= slot_q + 1'b1;
				end
				dclx_pkg::FSM_SRCH_H: begin
					head_q <= bs_rdata;
					if (mid_q == last_mid && bs_rdata > lba_q) begin
						e_q <= mid_q - SW'(1);
						mid_q <= (s_q + mid_q - SW'(1)) >>> 1;
					end
					i_q <= '0;
					acc_q <= '0;
				end
				dclx_pkg::FSM_SRCH_N: begin
					if (head_q > lba_q) begin
						e_q <= mid_q - SW'(1);
						mid_q <= (s_q + mid_q - SW'(1)) >>> 1;
					end else if (bs_rdata <= lba_q) begin
						s_q <= mid_q + SW'(1);
						mid_q <= (mid_q + SW'(1) + e_q) >>> 1;
					end
				end
				dclx_pkg::FSM_SCAN_RD: begin
					if (i_q == '0) begin
						pos_q <= BAw'(mid_q) * BAw'(dclx_pkg::ChunkStride);
						ci_q <= CntW'(mid_q) * epc_q;
						valid_q <= (count_q - CntW'(CntW'(mid_q) * epc_q) > epc_q) ? epc_q
							: count_q - CntW'(CntW'(mid_q) * epc_q);
					end
				end
				dclx_pkg::FSM_SCAN: begin
					acc_q <= scan_sum;
					pos_q <= pos_q + ((i_q == '0) ? BAw'(4) : BAw'(gb_q));
					i_q <= i_q + 1'b1;
					if (scan_sum == lba_q) begin
						status_q <= dclx_pkg::ST_FOUND;
						index_q <= 9'(ci_q + i_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result = '0;
		result.status = status_q;
		result.index = index_q;
		if (built_q) begin
			result.delta_bytes = gb_q;
			result.chunk_count = nchunk_q;
			result.stored_bits = 19'(20'(nchunk_q) * 20'(dclx_pkg::ChunkBits));
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_found_built: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == dclx_pkg::ST_FOUND) |-> built_q)
		else $error("hit on unbuilt set");
endmodule
